// File: rtl/core/rars_pkg.sv
// shared types and constants for the range-add range-sum store
package rars_pkg;

  localparam int unsigned ELEMENTS_DEF = 1024;
  localparam int unsigned IDX_W = 11;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned OP_W = 2;
  localparam int unsigned TDATA_IN_W = 88;
  localparam int unsigned TDATA_OUT_W = 64;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_ADD = 2'd1,
    OP_SUM = 2'd2,
    OP_NOP = 2'd3
  } op_e;

  // back part states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_CLR,
    ST_OUT
  } back_st_e;

  // one classified item as it sits in the queue
  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [VAL_W-1:0] val;
  } cmd_t;

endpackage

// File: rtl/core/rars_front.sv
// front part: accepts items, drops no-effect ones, feeds a two-entry queue
module rars_front #(
  parameter int unsigned ELEMENTS = rars_pkg::ELEMENTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rars_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  output logic                               cmd_valid_o,
  input  logic                               cmd_ready_i,
  output rars_pkg::cmd_t                     cmd_o
);

  rars_pkg::cmd_t q_mem [2];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  rars_pkg::cmd_t in_cmd;
  logic           keep, push, pop;

  assign in_cmd.op  = rars_pkg::op_e'(s_axis_tdata[1:0]);
  assign in_cmd.lo  = s_axis_tdata[12:2];
  assign in_cmd.hi  = s_axis_tdata[23:13];
  assign in_cmd.val = s_axis_tdata[87:24];

  // a set beyond the end, an empty add and an unused code are dropped here
  always_comb begin
    case (in_cmd.op)
      rars_pkg::OP_SET: keep = ({21'd0, in_cmd.lo} < 32'(ELEMENTS));
      rars_pkg::OP_ADD: keep = (in_cmd.lo < in_cmd.hi);
      rars_pkg::OP_SUM: keep = 1'b1;
      default:          keep = 1'b0;
    endcase
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready && keep;
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign pop           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = q_mem[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= in_cmd;
    end
  end

endmodule

// File: rtl/core/rars_back.sv
// back part: walks a range element by element over a flat element memory
module rars_back #(
  parameter int unsigned ELEMENTS = rars_pkg::ELEMENTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  rars_pkg::cmd_t                     cmd_i,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rars_pkg::TDATA_OUT_W-1:0]   m_axis_tdata
);

  // the store is held as a flat element array; each step covers one element,
  // so a range is walked element by element
  localparam int unsigned AW = (ELEMENTS <= 2) ? 1 : $clog2(ELEMENTS);
  localparam int unsigned CW = (AW + 1 > rars_pkg::IDX_W) ? AW + 1 : rars_pkg::IDX_W;

  rars_pkg::back_st_e st_q, st_d;
  logic [63:0]      elem_mem [ELEMENTS];
  logic [CW-1:0]    pos_q, pos_d, end_q, end_d;
  logic [63:0]      acc_q, acc_d, val_q, val_d;
  rars_pkg::op_e    op_q, op_d;
  logic [63:0]      rd_data_q;
  logic             wr_en;
  logic [63:0]      wr_data;
  logic [CW-1:0]    lim_hi;

  assign lim_hi = ({21'd0, cmd_i.hi} > 32'(ELEMENTS)) ? CW'(ELEMENTS) : CW'(cmd_i.hi);

  // unwritten entries read as zero through a clear sweep after reset
  // read address is the next position so the data lines up with pos_q
  always_ff @(posedge clk_i) begin
    if (wr_en) elem_mem[pos_q[AW-1:0]] <= wr_data;
    rd_data_q <= elem_mem[pos_d[AW-1:0]];
  end

  always_comb begin
    st_d = st_q; pos_d = pos_q; end_d = end_q; acc_d = acc_q;
    val_d = val_q; op_d = op_q; wr_en = 1'b0; wr_data = 64'd0;
    cmd_ready_o = 1'b0; m_axis_tvalid = 1'b0;
    case (st_q)
      rars_pkg::ST_CLR: begin
        wr_en = 1'b1;
        pos_d = pos_q + 1'b1;
        if (pos_q == CW'(ELEMENTS - 1)) begin
          st_d = rars_pkg::ST_IDLE;
          pos_d = '0;
        end
      end
      rars_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_d = cmd_i.op; val_d = cmd_i.val; acc_d = 64'd0;
          pos_d = CW'(cmd_i.lo);
          end_d = (cmd_i.op == rars_pkg::OP_SET) ? CW'(cmd_i.lo) + 1'b1 : lim_hi;
          st_d = (CW'(cmd_i.lo) < ((cmd_i.op == rars_pkg::OP_SET) ?
                 CW'(cmd_i.lo) + 1'b1 : lim_hi)) ? rars_pkg::ST_RUN :
                 ((cmd_i.op == rars_pkg::OP_SUM) ? rars_pkg::ST_OUT : rars_pkg::ST_IDLE);
        end
      end
      rars_pkg::ST_RUN: begin
        case (op_q)
          rars_pkg::OP_SET: begin wr_en = 1'b1; wr_data = val_q; end
          rars_pkg::OP_ADD: begin wr_en = 1'b1; wr_data = rd_data_q + val_q; end
          default:          acc_d = acc_q + rd_data_q;
        endcase
        pos_d = pos_q + 1'b1;
        if (pos_q + 1'b1 >= end_q) begin
          st_d = (op_q == rars_pkg::OP_SUM) ? rars_pkg::ST_OUT : rars_pkg::ST_IDLE;
        end
      end
      rars_pkg::ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) st_d = rars_pkg::ST_IDLE;
      end
      default: st_d = rars_pkg::ST_IDLE;
    endcase
  end

  assign m_axis_tdata = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= rars_pkg::ST_CLR;
      pos_q <= '0;
    end else begin
      st_q  <= st_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q <= end_d; acc_q <= acc_d; val_q <= val_d; op_q <= op_d;
  end

endmodule

// File: rtl/core/range_add_range_sum_tree_top.sv
// Range-add / range-sum store over ELEMENTS signed 64-bit values. Items are
// point sets, range adds over [lo,hi) and range-sum queries; only queries
// return an item. Sums wrap at 64 bits. After reset a clearing pass over
// all ELEMENTS entries runs before the first item is carried out. Each item
// walks the elements it touches one at a time, set by one element read and
// one element write per cycle, and a query then holds its result until it is
// taken; a two-entry queue parts intake from execution.
module range_add_range_sum_tree_top #(
  parameter int unsigned ELEMENTS = rars_pkg::ELEMENTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // operation[1:0], index_lo[12:2], index_hi[23:13], value[87:24]
  input  logic [rars_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // range_sum[63:0]
  output logic [rars_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);

  logic           cmd_valid, cmd_ready;
  rars_pkg::cmd_t cmd;

  rars_front #(.ELEMENTS(ELEMENTS)) u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  rars_back #(.ELEMENTS(ELEMENTS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("out dropped");
  a_no_take_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !cmd_ready) else $error("back took item during output");

endmodule

// File: verif/tb_range_add_range_sum_tree_top.sv
// testbench for the range-add range-sum store: directed table then random items
`timescale 1ns / 100ps

module tb_range_add_range_sum_tree_top;

  localparam int unsigned N_ELEM = rars_pkg::ELEMENTS_DEF;
  localparam int unsigned N_RANDOM = 1230;
  localparam int unsigned CALM_TAIL = 150;
  localparam int unsigned STALL_LIMIT = 30000;
  localparam int unsigned DRAIN_CYCLES = 2200;

  typedef struct {
    rars_pkg::op_e op;
    logic [10:0]   lo;
    logic [10:0]   hi;
    logic [63:0]   val;
    bit            typed;
    logic [63:0]   sum;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [rars_pkg::TDATA_IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [rars_pkg::TDATA_OUT_W-1:0] m_axis_tdata;

  logic [63:0] elem_vals [N_ELEM];
  logic [63:0] sums_due [$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  always #10 clk_i = ~clk_i;

  range_add_range_sum_tree_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // applies one item to the local copy and returns the query sum if any
  function automatic bit apply_item(rars_pkg::op_e op, logic [10:0] lo, logic [10:0] hi,
                                    logic [63:0] val, output logic [63:0] sum);
    int unsigned top;
    sum = '0;
    top = (hi > N_ELEM) ? N_ELEM : hi;
    case (op)
      rars_pkg::OP_SET: begin
        if (lo < N_ELEM) elem_vals[lo] = val;
      end
      rars_pkg::OP_ADD: begin
        for (int unsigned i = lo; i < top; i++) elem_vals[i] += val;
      end
      rars_pkg::OP_SUM: begin
        for (int unsigned i = lo; i < top; i++) sum += elem_vals[i];
      end
      default: ;
    endcase
    return op == rars_pkg::OP_SUM;
  endfunction

  task automatic send_item(rars_pkg::op_e op, logic [10:0] lo, logic [10:0] hi,
                           logic [63:0] val, bit typed, logic [63:0] typed_sum);
    logic [63:0] sum;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {val, hi, lo, op};
    do @(posedge clk_i); while (!s_axis_tready);
    if (apply_item(op, lo, hi, val, sum)) sums_due.push_back(typed ? typed_sum : sum);
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 64'h7fff_ffff_ffff_ffff;
      1: return 64'h8000_0000_0000_0000;
      2: return 64'(int'($urandom_range(0, 200)) - 100);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected item range_sum=%h", $time, m_axis_tdata);
        errors++;
      end else begin
        if (m_axis_tdata !== sums_due[0]) begin
          $display("%0t: range_sum expected %h actual %h", $time, sums_due[0], m_axis_tdata);
          errors++;
        end
        void'(sums_due.pop_front());
      end
    end
  end

  // receiver: random stalls plus one long hold
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (500) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_t rows [$];
    logic [10:0] lo, hi;
    rars_pkg::op_e op;
    for (int i = 0; i < N_ELEM; i++) elem_vals[i] = '0;
    rows = '{
      '{rars_pkg::OP_SUM, 11'd0, 11'd1024, 64'd0, 1'b1, 64'd0},
      '{rars_pkg::OP_SET, 11'd0, 11'd0, 64'h7fff_ffff_ffff_ffff, 1'b0, 64'd0},
      '{rars_pkg::OP_SET, 11'd1023, 11'd0, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
      '{rars_pkg::OP_SUM, 11'd0, 11'd1, 64'd0, 1'b1, 64'h7fff_ffff_ffff_ffff},
      '{rars_pkg::OP_SUM, 11'd0, 11'd1024, 64'd0, 1'b1, 64'hffff_ffff_ffff_ffff},
      '{rars_pkg::OP_ADD, 11'd0, 11'd1024, 64'hffff_ffff_ffff_ffff, 1'b0, 64'd0},
      '{rars_pkg::OP_SUM, 11'd0, 11'd1024, 64'd0, 1'b0, 64'd0},
      '{rars_pkg::OP_SUM, 11'd500, 11'd500, 64'd0, 1'b1, 64'd0},
      '{rars_pkg::OP_SUM, 11'd700, 11'd3, 64'h1234, 1'b1, 64'd0},
      '{rars_pkg::OP_ADD, 11'd9, 11'd4, 64'd77, 1'b0, 64'd0},
      '{rars_pkg::OP_ADD, 11'd9, 11'd9, 64'd77, 1'b0, 64'd0},
      '{rars_pkg::OP_SET, 11'd1024, 11'd0, 64'd5, 1'b0, 64'd0},
      '{rars_pkg::OP_SET, 11'd2047, 11'd2047, 64'd5, 1'b0, 64'd0},
      '{rars_pkg::OP_NOP, 11'd0, 11'd1024, 64'hffff_ffff_ffff_ffff, 1'b0, 64'd0},
      '{rars_pkg::OP_ADD, 11'd1000, 11'd2047, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
      '{rars_pkg::OP_SUM, 11'd1020, 11'd2047, 64'd0, 1'b0, 64'd0},
      '{rars_pkg::OP_SUM, 11'd2047, 11'd2047, 64'd0, 1'b1, 64'd0},
      '{rars_pkg::OP_ADD, 11'd3, 11'd17, 64'd12345, 1'b0, 64'd0},
      '{rars_pkg::OP_SET, 11'd5, 11'd0, 64'd1, 1'b0, 64'd0},
      '{rars_pkg::OP_SUM, 11'd0, 11'd20, 64'd0, 1'b0, 64'd0},
      '{rars_pkg::OP_SUM, 11'd1023, 11'd1024, 64'd0, 1'b0, 64'd0},
      '{rars_pkg::OP_SUM, 11'd1024, 11'd2047, 64'd0, 1'b1, 64'd0}
    };
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) send_item(rows[i].op, rows[i].lo, rows[i].hi, rows[i].val,
                                rows[i].typed, rows[i].sum);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 700) begin
        // sender pauses until all sums are back
        s_axis_tvalid <= 1'b0;
        while (sums_due.size() != 0) @(negedge clk_i);
      end
      if (n == N_RANDOM - CALM_TAIL) calm = 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: op = rars_pkg::OP_SET;
        5, 6, 7, 8, 9, 10: op = rars_pkg::OP_ADD;
        11: op = rars_pkg::OP_NOP;
        default: op = rars_pkg::OP_SUM;
      endcase
      case ($urandom_range(0, 39))
        0: begin lo = 11'd0; hi = 11'd1024; end
        1: begin lo = 11'($urandom_range(0, 2047)); hi = 11'($urandom_range(0, 2047)); end
        2: begin lo = 11'($urandom_range(990, 1023)); hi = 11'($urandom_range(1024, 2047)); end
        3: begin lo = 11'($urandom_range(0, 40)); hi = 11'($urandom_range(0, 40)); end
        default: begin
          lo = 11'($urandom_range(0, 1023));
          hi = lo + 11'($urandom_range(1, 32));
        end
      endcase
      if (op == rars_pkg::OP_SET && $urandom_range(0, 19) == 0) begin
        lo = 11'($urandom_range(1024, 2047));
      end
      send_item(op, lo, hi, rand_val(), 1'b0, 64'd0);
    end
    s_axis_tvalid <= 1'b0;
    while (sums_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && sums_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
